/* hw/rtl/pslt_pkg.sv */
// Shared types and constants for the position score lookup table.
`timescale 1ns / 1ps
`default_nettype none

package pslt_pkg;

    localparam int KEY_W       = 64;
    localparam int DEPTH_W     = 6;
    localparam int SCORE_W     = 21;
    localparam int OP_W        = 2;
    localparam int ENTRIES_DEF = 1024;

    localparam logic signed [SCORE_W-1:0] SCORE_MAX = 21'sd1000000;
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = -21'sd1000000;

    // Request codes
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // One stored entry
    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic [DEPTH_W-1:0]        depth;
        logic signed [SCORE_W-1:0] score;
    } entry_t;

    // Saturate a score to the legal range
    function automatic logic signed [SCORE_W-1:0] clamp_score(
        input logic signed [SCORE_W-1:0] s
    );
        logic signed [SCORE_W-1:0] r;
        r = s;
        if (s > SCORE_MAX)
        begin
            r = SCORE_MAX;
        end
        else if (s < SCORE_MIN)
        begin
            r = SCORE_MIN;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/pslt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module pslt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* hw/rtl/position_score_lookup_table_unit.sv */
// Position score lookup table: entry RAM, scan sequencer and result register.
// Insert, clear, unused codes: result loaded from ST_PUSH once the output slot is free.
// Lookup: one RAM read and one key/depth compare per cycle, in index order, stopping
// at the first match or the last valid entry; an empty table skips the scan. The result
// is loaded from ST_PUSH once the output slot is free. One request at a time; the next
// is taken once the result moves to the output register. Reset empties the table at once
// through the pointer and a full flag (no clearing pass); RAM contents are not reset.
`timescale 1ns / 1ps
`default_nettype none

module position_score_lookup_table_unit
    import pslt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [OP_W-1:0]           operation,
    input  wire logic [KEY_W-1:0]          key,
    input  wire logic [DEPTH_W-1:0]        depth,
    input  wire logic signed [SCORE_W-1:0] score_in,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic                           hit,
    output logic signed [SCORE_W-1:0]      score_out
);

    localparam int AW = $clog2(ENTRIES);
    localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_PUSH = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic          full_reg, full_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [AW-1:0] last_reg, last_next;
    logic [KEY_W-1:0]          key_reg, key_next;
    logic [DEPTH_W-1:0]        depth_reg, depth_next;
    logic                      res_hit_reg, res_hit_next;
    logic signed [SCORE_W-1:0] res_score_reg, res_score_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      hit_reg, hit_next;
    logic signed [SCORE_W-1:0] score_out_reg, score_out_next;

    logic          accept;
    logic          empty;
    logic          slot_free;
    logic          match;
    logic [AW-1:0] ptr_inc;
    logic [AW-1:0] addr_inc;
    logic [AW-1:0] start_addr;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    entry_t        wr_data;
    entry_t        rd_data;

    // Entry store
    pslt_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (ENTRIES),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (ptr_inc),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Handshake and address helpers
    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign slot_free  = !out_valid_reg || out_ready;
    assign ptr_inc    = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + 1'b1;
    assign addr_inc   = (addr_reg == LAST_IDX) ? '0 : addr_reg + 1'b1;
    // Before the pointer first wraps, valid entries run from index 1 to the pointer
    assign start_addr = full_reg ? '0 : AW'(1);
    assign empty      = !full_reg && (ptr_reg == '0);
    assign rd_addr    = (state_reg == ST_SCAN) ? addr_inc : start_addr;
    assign match      = (rd_data.key == key_reg) && (rd_data.depth == depth_reg);
    assign wr_en      = accept && (operation == OP_INSERT);
    assign wr_data    = '{key: key, depth: depth, score: clamp_score(score_in)};

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        full_next      = full_reg;
        addr_next      = addr_reg;
        last_next      = last_reg;
        key_next       = key_reg;
        depth_next     = depth_reg;
        res_hit_next   = res_hit_reg;
        res_score_next = res_score_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_hit_next   = 1'b0;
                    res_score_next = '0;
                    state_next     = ST_PUSH;
                    case (operation)
                        OP_LOOKUP:
                        begin
                            if (!empty)
                            begin
                                addr_next  = start_addr;
                                last_next  = full_reg ? LAST_IDX : ptr_reg;
                                key_next   = key;
                                depth_next = depth;
                                state_next = ST_SCAN;
                            end
                        end
                        OP_INSERT:
                        begin
                            ptr_next = ptr_inc;
                            if (ptr_reg == LAST_IDX)
                            begin
                                full_next = 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            ptr_next  = '0;
                            full_next = 1'b0;
                        end
                        default:
                        begin
                            ptr_next = ptr_reg;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // Compare the entry read last cycle; stop at the first match
                if (match)
                begin
                    res_hit_next   = 1'b1;
                    res_score_next = rd_data.score;
                    state_next     = ST_PUSH;
                end
                else if (addr_reg == last_reg)
                begin
                    state_next = ST_PUSH;
                end
                else
                begin
                    addr_next = addr_inc;
                end
            end
            ST_PUSH:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: load the pending result once the slot is free
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        hit_next       = hit_reg;
        score_out_next = score_out_reg;
        if ((state_reg == ST_PUSH) && slot_free)
        begin
            out_valid_next = 1'b1;
            hit_next       = res_hit_reg;
            score_out_next = res_score_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        last_reg      <= last_next;
        key_reg       <= key_next;
        depth_reg     <= depth_next;
        res_hit_reg   <= res_hit_next;
        res_score_reg <= res_score_next;
        hit_reg       <= hit_next;
        score_out_reg <= score_out_next;
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign score_out = score_out_reg;

endmodule

`default_nettype wire
